// ===== hw/rtl/frqs_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frqs_pkg: shared types and constants of the ready-queue scheduler
// Operation codes, queue membership codes and recorded slot states.
// ----------------------------------------------------------------------------
package frqs_pkg;

  localparam int unsigned NumSlotsDefault = 16;
  localparam int unsigned FuncW  = 3;
  localparam int unsigned SlotW  = 4;
  localparam int unsigned StateW = 2;

  localparam logic [FuncW-1:0] FuncMakeReady  = 3'd0;
  localparam logic [FuncW-1:0] FuncSuspend    = 3'd1;
  localparam logic [FuncW-1:0] FuncStop       = 3'd2;
  localparam logic [FuncW-1:0] FuncDispatched = 3'd3;
  localparam logic [FuncW-1:0] FuncBoost      = 3'd4;
  localparam logic [FuncW-1:0] FuncQuery      = 3'd5;

  localparam logic [1:0] ListNone  = 2'd0;
  localparam logic [1:0] ListReady = 2'd1;
  localparam logic [1:0] ListSleep = 2'd2;

  localparam logic [StateW-1:0] StStopped   = 2'd0;
  localparam logic [StateW-1:0] StReady     = 2'd1;
  localparam logic [StateW-1:0] StSuspended = 2'd2;

endpackage

// ===== hw/rtl/fifo_ready_queue_scheduler.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fifo_ready_queue_scheduler: FIFO ready queue of virtual-CPU slots
// Doubly linked ready and sleep queues held in a per-slot entry memory.
// ----------------------------------------------------------------------------
// Usage:
// A request is a transfer of func_i and slot_id_i, taken at a rising edge
// where start_i is high and busy_o is low. The block then goes busy and
// produces exactly one result, marked by done_o for a single cycle; the
// receiver cannot stall it, so the result must be captured in that cycle.
// State SRead then takes in the named slot's entry, read from the slot
// memories. A dropped request, a query or an unused func code goes
// straight from there to the result state SDone. Any other operation
// first unlinks the slot from its old neighbors in SFixP, then writes the
// slot's own entry for its new queue in SFixN, then points the new
// neighbor back at the slot in SLink, and only then reaches SDone.
// busy_o stays high with done_o and falls once the block is back in SIdle,
// so the next start is taken in the cycle after the result; the block takes
// no new request before its last result. Write the idle slot register
// through cfg_we_i/cfg_wdata_i only while idle; the block does not enforce it.
// Reset empties both queues and marks every slot stopped and on no queue;
// the memories are swept clear after reset, and busy_o stays high meanwhile.
// ----------------------------------------------------------------------------
module fifo_ready_queue_scheduler #(
  parameter int unsigned NUM_SLOTS = frqs_pkg::NumSlotsDefault
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [frqs_pkg::SlotW-1:0]  cfg_wdata_i,
  input  logic                        start_i,
  output logic                        busy_o,
  input  logic [frqs_pkg::FuncW-1:0]  func_i,
  input  logic [frqs_pkg::SlotW-1:0]  slot_id_i,
  output logic                        done_o,
  output logic [frqs_pkg::SlotW-1:0]  next_slot_o,
  output logic                        next_is_idle_o,
  output logic                        ready_empty_o,
  output logic                        ignored_o,
  output logic [frqs_pkg::StateW-1:0] slot_state_o
);
  import frqs_pkg::*;

  localparam int unsigned IdxW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int unsigned LnkW = $clog2(NUM_SLOTS + 1);
  localparam logic [LnkW-1:0] Nil = LnkW'(NUM_SLOTS);

  typedef enum logic [6:0] {
    SClear = 7'b0000001,
    SIdle  = 7'b0000010,
    SRead  = 7'b0000100,
    SFixP  = 7'b0001000,
    SFixN  = 7'b0010000,
    SLink  = 7'b0100000,
    SDone  = 7'b1000000
  } state_e;

  // Separate memories per field: next links, prev links, list and status.
  logic [LnkW-1:0]   nxt_mem [NUM_SLOTS];
  logic [LnkW-1:0]   prv_mem [NUM_SLOTS];
  logic [1:0]        lst_mem [NUM_SLOTS];
  logic [StateW-1:0] sts_mem [NUM_SLOTS];

  state_e state_q, state_d;
  logic [IdxW-1:0]   clr_q;
  logic [SlotW-1:0]  idle_q;
  logic [FuncW-1:0]  func_q;
  logic [IdxW-1:0]   s_q;
  logic              ign_q, oor_q;
  logic [LnkW-1:0]   rhead_q, rtail_q, shead_q, stail_q;
  logic [LnkW-1:0]   rhead_d, rtail_d, shead_d, stail_d;
  logic [LnkW-1:0]   p_q, n_q;     // captured old links of the slot
  logic [1:0]        lst_q;
  logic [StateW-1:0] sts_q;

  // Read data, registered.
  logic [LnkW-1:0]   nxt_rd_q, prv_rd_q;
  logic [1:0]        lst_rd_q;
  logic [StateW-1:0] sts_rd_q;

  // Write ports, one per memory.
  logic              nxt_we, prv_we, lst_we, sts_we;
  logic [IdxW-1:0]   nxt_wa, prv_wa, lst_wa, sts_wa;
  logic [LnkW-1:0]   nxt_wd, prv_wd;
  logic [1:0]        lst_wd;
  logic [StateW-1:0] sts_wd;

  // Neighbor captured when the slot is linked in.
  logic [LnkW-1:0]   nxt_wd_q, prv_wd_q;

  logic [IdxW-1:0]   rd_a;
  logic              op_valid, push_front, push_back_r, push_back_s;
  logic [1:0]        new_lst;
  logic [StateW-1:0] new_sts;
  logic              new_sts_we;
  logic              sid_oor;

  always_ff @(posedge clk_i) begin
    if (nxt_we) nxt_mem[nxt_wa] <= nxt_wd;
    if (prv_we) prv_mem[prv_wa] <= prv_wd;
    if (lst_we) lst_mem[lst_wa] <= lst_wd;
    if (sts_we) sts_mem[sts_wa] <= sts_wd;
    nxt_rd_q <= nxt_mem[rd_a];
    prv_rd_q <= prv_mem[rd_a];
    lst_rd_q <= lst_mem[rd_a];
    sts_rd_q <= sts_mem[rd_a];
  end

  assign rd_a = IdxW'(slot_id_i);

  // A slot number at or above NUM_SLOTS names no slot.
  assign sid_oor = (32'(slot_id_i) >= NUM_SLOTS);

  // A real operation: valid slot, not idle, func 0..4.
  assign op_valid    = !ign_q && (func_q <= FuncBoost);
  assign push_front  = (func_q == FuncMakeReady) || (func_q == FuncBoost);
  assign push_back_r = (func_q == FuncDispatched);
  assign push_back_s = (func_q == FuncSuspend);

  always_comb begin
    unique case (func_q)
      FuncMakeReady, FuncDispatched, FuncBoost: new_lst = ListReady;
      FuncSuspend:                              new_lst = ListSleep;
      default:                                  new_lst = ListNone;
    endcase
    new_sts_we = 1'b1;
    unique case (func_q)
      FuncMakeReady: new_sts = StReady;
      FuncSuspend:   new_sts = StSuspended;
      FuncStop:      new_sts = StStopped;
      default: begin
        new_sts    = sts_q;
        new_sts_we = 1'b0;
      end
    endcase
  end

  // Head/tail after unlink, computed from captured links and list.
  logic [LnkW-1:0] uh_r, ut_r, uh_s, ut_s;
  always_comb begin
    uh_r = rhead_q; ut_r = rtail_q; uh_s = shead_q; ut_s = stail_q;
    if (lst_q == ListReady) begin
      if (p_q == Nil) uh_r = n_q;
      if (n_q == Nil) ut_r = p_q;
    end else if (lst_q == ListSleep) begin
      if (p_q == Nil) uh_s = n_q;
      if (n_q == Nil) ut_s = p_q;
    end
  end

  always_comb begin
    state_d = state_q;
    nxt_we = 1'b0; prv_we = 1'b0; lst_we = 1'b0; sts_we = 1'b0;
    nxt_wa = s_q;  prv_wa = s_q;  lst_wa = s_q;  sts_wa = s_q;
    nxt_wd = Nil;  prv_wd = Nil;  lst_wd = ListNone; sts_wd = StStopped;
    rhead_d = rhead_q; rtail_d = rtail_q; shead_d = shead_q; stail_d = stail_q;
    unique case (state_q)
      SClear: begin
        nxt_we = 1'b1; prv_we = 1'b1; lst_we = 1'b1; sts_we = 1'b1;
        nxt_wa = clr_q; prv_wa = clr_q; lst_wa = clr_q; sts_wa = clr_q;
        if (clr_q == IdxW'(NUM_SLOTS - 1)) state_d = SIdle;
      end
      SIdle: if (start_i) state_d = SRead;
      SRead: state_d = op_valid ? SFixP : SDone;
      SFixP: begin
        // Patch predecessor's next (or head), and successor's prev (or tail).
        if (lst_q != ListNone) begin
          if (p_q != Nil) begin
            nxt_we = 1'b1; nxt_wa = IdxW'(p_q); nxt_wd = n_q;
          end
          if (n_q != Nil) begin
            prv_we = 1'b1; prv_wa = IdxW'(n_q); prv_wd = p_q;
          end
          if (lst_q == ListReady) begin
            rhead_d = uh_r; rtail_d = ut_r;
          end else begin
            shead_d = uh_s; stail_d = ut_s;
          end
        end
        state_d = SFixN;
      end
      SFixN: begin
        // Link the slot into its new queue; head/tail now are post-unlink.
        lst_we = 1'b1; lst_wd = new_lst;
        sts_we = new_sts_we; sts_wd = new_sts;
        nxt_we = 1'b1; prv_we = 1'b1;
        if (push_front) begin
          prv_wd = Nil; nxt_wd = rhead_q;
          rhead_d = LnkW'(s_q);
          if (rhead_q == Nil) rtail_d = LnkW'(s_q);
        end else if (push_back_r) begin
          nxt_wd = Nil; prv_wd = rtail_q;
          rtail_d = LnkW'(s_q);
          if (rtail_q == Nil) rhead_d = LnkW'(s_q);
        end else if (push_back_s) begin
          nxt_wd = Nil; prv_wd = stail_q;
          stail_d = LnkW'(s_q);
          if (stail_q == Nil) shead_d = LnkW'(s_q);
        end
        state_d = SLink;
      end
      SLink: begin
        // Point the new neighbor back at the slot.
        if (push_front && (nxt_wd_q != Nil)) begin
          prv_we = 1'b1; prv_wa = IdxW'(nxt_wd_q); prv_wd = LnkW'(s_q);
        end else if ((push_back_r || push_back_s) && (prv_wd_q != Nil)) begin
          nxt_we = 1'b1; nxt_wa = IdxW'(prv_wd_q); nxt_wd = LnkW'(s_q);
        end
        state_d = SDone;
      end
      SDone: state_d = SIdle;
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SClear;
      clr_q   <= '0;
      idle_q  <= '0;
      rhead_q <= Nil; rtail_q <= Nil; shead_q <= Nil; stail_q <= Nil;
    end else begin
      state_q <= state_d;
      if (state_q == SClear) clr_q <= clr_q + 1'b1;
      if (cfg_we_i) idle_q <= cfg_wdata_i;
      rhead_q <= rhead_d; rtail_q <= rtail_d;
      shead_q <= shead_d; stail_q <= stail_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == SIdle && start_i) begin
      func_q <= func_i;
      s_q    <= IdxW'(slot_id_i);
      oor_q  <= sid_oor;
      ign_q  <= sid_oor || (slot_id_i == idle_q);
    end
    if (state_q == SRead) begin
      p_q   <= prv_rd_q;
      n_q   <= nxt_rd_q;
      lst_q <= lst_rd_q;
      sts_q <= sts_rd_q;
    end
    if (state_q == SFixN) begin
      nxt_wd_q <= nxt_wd;
      prv_wd_q <= prv_wd;
      if (new_sts_we) sts_q <= new_sts;
    end
  end

  assign busy_o         = (state_q != SIdle);
  assign done_o         = (state_q == SDone);
  assign ready_empty_o  = (rhead_q == Nil);
  assign next_is_idle_o = ready_empty_o;
  assign next_slot_o    = ready_empty_o ? idle_q : SlotW'(rhead_q);
  assign ignored_o      = ign_q;
  assign slot_state_o   = oor_q ? StStopped : sts_q;

  // Assertions.
  a_done_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("done lasted more than one cycle");
  a_head_tail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == SIdle) |-> ((rhead_q == Nil) == (rtail_q == Nil)))
    else $error("ready head and tail disagree on emptiness");
  a_sleep_ht: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == SIdle) |-> ((shead_q == Nil) == (stail_q == Nil)))
    else $error("sleep head and tail disagree on emptiness");
  a_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && state_q == SIdle) |=> (state_q == SRead))
    else $error("accepted request did not start a read");

endmodule
